>>> design/text_to_int64_parser_core_defines.svh
// assertion macros shared by the parser modules
// each macro takes a label, the clock, the active-low reset and two expressions
`ifndef TEXT_TO_INT64_PARSER_CORE_DEFINES_SVH
`define TEXT_TO_INT64_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define T2I_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("t2i64 same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define T2I_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("t2i64 next-cycle check failed");

`else

`define T2I_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define T2I_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/t2i64_pkg.sv
`timescale 1ns / 1ps

package t2i64_pkg;

  // field widths
  localparam int unsigned CharW      = 8;
  localparam int unsigned BaseW      = 6;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned EndOffsetW = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = BaseW;

  // default width of the saturating character counter
  localparam int unsigned OffsetBitsDefault = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SIGNED_MODE = 1'b1;

  // character codes
  localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CHAR_UPPER_OFS = 8'h37;  // 'A' - 10
  localparam logic [CharW-1:0] CHAR_LOWER_OFS = 8'h57;  // 'a' - 10
  localparam logic [CharW-1:0] CHAR_LOWER_X = 8'h78;
  localparam logic [CharW-1:0] CHAR_UPPER_X = 8'h58;
  localparam logic [CharW-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CharW-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR      = 8'h0D;

  // bases picked by prefix detection
  localparam logic [BaseW-1:0] BASE_DEC = 6'd10;
  localparam logic [BaseW-1:0] BASE_OCT = 6'd8;
  localparam logic [BaseW-1:0] BASE_HX  = 6'd16;

  // saturation limits
  localparam logic [ValueW-1:0] LIMIT_SIGNED_MAX = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] LIMIT_SIGNED_MIN = {1'b1, {(ValueW-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_SOME,
    ST_OVER
  } digit_status_e;

  // where the base used for this character comes from
  typedef enum logic [1:0] {
    BASE_KEEP,
    BASE_FIRST,
    BASE_OCTAL,
    BASE_HEX
  } base_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      clear;
    logic      step;
    logic      set_neg;
    base_sel_e base_sel;
    logic      pre_zero;
    logic      digit;
    logic      finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_space;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic base_zero_hex;
    logic digit_ok_first;
    logic digit_ok_octal;
    logic digit_ok_keep;
    logic out_full;
  } dp_status_t;

  typedef struct packed {
    logic             valid;
    logic [BaseW-1:0] value;
  } char_digit_t;

  // digit value of a character, letters count from ten
  function automatic char_digit_t char_digit(input logic [CharW-1:0] c);
    char_digit_t r;
    logic [CharW-1:0] diff;
    r.valid = 1'b1;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_OFS;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff = c - CHAR_LOWER_OFS;
    end else begin
      r.valid = 1'b0;
    end
    r.value = diff[BaseW-1:0];
    return r;
  endfunction

endpackage

>>> design/t2i64_intf.sv
`timescale 1ns / 1ps

// character request channel
interface t2i64_in_if;
  logic                          valid;
  logic                          ready;
  logic [t2i64_pkg::CharW-1:0]   char_code;
  logic                          string_start;

  modport source (output valid, char_code, string_start, input ready);
  modport sink   (input valid, char_code, string_start, output ready);
endinterface

// conversion result channel
interface t2i64_out_if;
  logic                             valid;
  logic                             ready;
  logic [t2i64_pkg::ValueW-1:0]     value_bits;
  logic                             range_error;
  logic                             converted;
  logic [t2i64_pkg::EndOffsetW-1:0] end_offset;

  modport source (output valid, value_bits, range_error, converted, end_offset, input ready);
  modport sink   (input valid, value_bits, range_error, converted, end_offset, output ready);
endinterface

>>> design/text_to_int64_parser_core.sv
`timescale 1ns / 1ps

// Streaming string-to-integer converter with strtoull / strtoll behavior. It takes one
// character per request; string_start opens a new string (an unfinished one is dropped).
// Leading whitespace and one sign are skipped, base 0 or 16 honors a 0x / 0X prefix and
// base 0 picks octal after a leading zero, decimal otherwise. Overflow saturates to all
// ones (unsigned) or to the signed min / max, with range_error set. The first character
// that is not a digit of the base yields one result with its index in end_offset (0 if
// nothing converted); characters after that, or before any string_start, give nothing.
// A new character is taken every cycle while the result register is free or being
// drained; the datapath's 64 x 6 bit multiply-add and overflow compare against the limit
// set the cycle. A result waiting on a stalled sink holds off further characters. The
// user writes number_base and signed_mode only between strings; the block has no check.
module text_to_int64_parser_core #(
  parameter int unsigned OffsetBits = t2i64_pkg::OffsetBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [t2i64_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [t2i64_pkg::CfgDataW-1:0] cfg_wdata_i,
  t2i64_in_if.sink                       in_if,
  t2i64_out_if.source                    out_if
);

  t2i64_pkg::dp_cmd_t    cmd;
  t2i64_pkg::dp_status_t status;

  // phase sequencing and handshake
  t2i64_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .string_start_i (in_if.string_start),
    .out_ready_i    (out_if.ready),
    .status_i       (status),
    .in_ready_o     (in_if.ready),
    .cmd_o          (cmd)
  );

  // accumulator, counters and result register
  t2i64_dp #(
    .OffsetBits (OffsetBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .char_code_i   (in_if.char_code),
    .out_ready_i   (out_if.ready),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_if.valid),
    .value_bits_o  (out_if.value_bits),
    .range_error_o (out_if.range_error),
    .converted_o   (out_if.converted),
    .end_offset_o  (out_if.end_offset)
  );

endmodule

>>> design/t2i64_ctrl.sv
`timescale 1ns / 1ps
`include "text_to_int64_parser_core_defines.svh"

module t2i64_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  string_start_i,
  input  logic                  out_ready_i,
  input  t2i64_pkg::dp_status_t status_i,
  output logic                  in_ready_o,
  output t2i64_pkg::dp_cmd_t    cmd_o
);

  t2i64_pkg::phase_e phase_q, phase_d, phase_cur;
  logic accept;
  logic first;

  // the output register frees up when the sink takes it
  assign in_ready_o = !status_i.out_full || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // a start flag opens the string on this very character
  assign phase_cur = string_start_i ? t2i64_pkg::PH_LEAD : phase_q;

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= t2i64_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // next phase and datapath commands
  always_comb begin
    phase_d        = phase_q;
    cmd_o          = '0;
    cmd_o.base_sel = t2i64_pkg::BASE_KEEP;
    first          = 1'b0;
    if (accept) begin
      phase_d     = phase_cur;
      cmd_o.clear = string_start_i;
      cmd_o.step  = (phase_cur != t2i64_pkg::PH_IDLE) && (phase_cur != t2i64_pkg::PH_DONE);
      case (phase_cur)
        t2i64_pkg::PH_LEAD: begin
          if (status_i.is_space) begin
            phase_d = t2i64_pkg::PH_LEAD;
          end else if (status_i.is_minus) begin
            cmd_o.set_neg = 1'b1;
            phase_d       = t2i64_pkg::PH_SIGNED;
          end else if (status_i.is_plus) begin
            phase_d = t2i64_pkg::PH_SIGNED;
          end else begin
            first = 1'b1;
          end
        end
        t2i64_pkg::PH_SIGNED: begin
          first = 1'b1;
        end
        t2i64_pkg::PH_ZERO: begin
          if (status_i.is_x) begin
            cmd_o.base_sel = t2i64_pkg::BASE_HEX;
            phase_d        = t2i64_pkg::PH_PREFIX;
          end else begin
            // the leading zero counts as a digit
            cmd_o.base_sel = t2i64_pkg::BASE_OCTAL;
            cmd_o.pre_zero = 1'b1;
            phase_d        = t2i64_pkg::PH_DIGITS;
            cmd_o.digit    = status_i.digit_ok_octal;
            cmd_o.finish   = !status_i.digit_ok_octal;
          end
        end
        t2i64_pkg::PH_PREFIX, t2i64_pkg::PH_DIGITS: begin
          phase_d      = t2i64_pkg::PH_DIGITS;
          cmd_o.digit  = status_i.digit_ok_keep;
          cmd_o.finish = !status_i.digit_ok_keep;
        end
        default: begin
          phase_d = phase_cur;
        end
      endcase

      // first character of the number itself
      if (first) begin
        if (status_i.base_zero_hex && status_i.is_zero) begin
          phase_d = t2i64_pkg::PH_ZERO;
        end else begin
          cmd_o.base_sel = t2i64_pkg::BASE_FIRST;
          phase_d        = t2i64_pkg::PH_DIGITS;
          cmd_o.digit    = status_i.digit_ok_first;
          cmd_o.finish   = !status_i.digit_ok_first;
        end
      end

      if (cmd_o.finish) begin
        phase_d = t2i64_pkg::PH_DONE;
      end
    end
  end

  `T2I_ASSERT_NEXT(a_finish_to_done, clk_i, rst_ni, cmd_o.finish, phase_q == t2i64_pkg::PH_DONE)
  `T2I_ASSERT_IMPLIES(a_digit_not_finish, clk_i, rst_ni, cmd_o.digit, !cmd_o.finish)

endmodule

>>> design/t2i64_dp.sv
`timescale 1ns / 1ps
`include "text_to_int64_parser_core_defines.svh"

module t2i64_dp #(
  parameter int unsigned OffsetBits = t2i64_pkg::OffsetBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [t2i64_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [t2i64_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic [t2i64_pkg::CharW-1:0]          char_code_i,
  input  logic                                 out_ready_i,
  input  t2i64_pkg::dp_cmd_t                   cmd_i,
  output t2i64_pkg::dp_status_t                status_o,
  output logic                                 out_valid_o,
  output logic [t2i64_pkg::ValueW-1:0]         value_bits_o,
  output logic                                 range_error_o,
  output logic                                 converted_o,
  output logic [t2i64_pkg::EndOffsetW-1:0]     end_offset_o
);

  localparam int unsigned ValueW = t2i64_pkg::ValueW;
  localparam int unsigned BaseW  = t2i64_pkg::BaseW;
  localparam int unsigned EndW   = t2i64_pkg::EndOffsetW;
  localparam int unsigned ExtW   = (OffsetBits > EndW) ? OffsetBits : EndW;

  // configuration
  logic [BaseW-1:0] number_base_q;
  logic             signed_mode_q;

  // string state
  logic [ValueW-1:0]        acc_q, acc_d, acc_cur;
  logic                     neg_q, neg_d, neg_cur;
  t2i64_pkg::digit_status_e stat_q, stat_d, stat_cur, stat_pre;
  logic [BaseW-1:0]         base_q, base_d, base_cur;
  logic [OffsetBits-1:0]    pos_q, pos_d, pos_cur;

  // result register
  logic              out_valid_q;
  logic [ValueW-1:0] value_q;
  logic              range_q;
  logic              conv_q;
  logic [EndW-1:0]   end_q;

  t2i64_pkg::char_digit_t cd;
  logic [BaseW-1:0]        base_dec, base_oct, base_act, base_eff;
  logic [ValueW-1:0]       limit;
  logic [ValueW+BaseW-1:0] prod;
  logic [ValueW+BaseW:0]   sum;
  logic                    over;
  logic [ExtW-1:0]         pos_ext;
  logic [ValueW-1:0]       res_value;
  logic                    res_conv;

  // character classes
  assign cd = t2i64_pkg::char_digit(char_code_i);
  assign status_o.is_space = (char_code_i == t2i64_pkg::CHAR_SPACE) ||
                             ((char_code_i >= t2i64_pkg::CHAR_TAB) &&
                              (char_code_i <= t2i64_pkg::CHAR_CR));
  assign status_o.is_minus = char_code_i == t2i64_pkg::CHAR_MINUS;
  assign status_o.is_plus  = char_code_i == t2i64_pkg::CHAR_PLUS;
  assign status_o.is_zero  = char_code_i == t2i64_pkg::CHAR_ZERO;
  assign status_o.is_x     = (char_code_i == t2i64_pkg::CHAR_LOWER_X) ||
                             (char_code_i == t2i64_pkg::CHAR_UPPER_X);
  assign status_o.base_zero_hex = (number_base_q == '0) ||
                                  (number_base_q == t2i64_pkg::BASE_HX);

  // current state, as cleared by a string start
  assign acc_cur  = cmd_i.clear ? '0 : acc_q;
  assign neg_cur  = cmd_i.clear ? 1'b0 : neg_q;
  assign stat_cur = cmd_i.clear ? t2i64_pkg::ST_NONE : stat_q;
  assign base_cur = cmd_i.clear ? '0 : base_q;
  assign pos_cur  = cmd_i.clear ? '0 : pos_q;
  assign stat_pre = cmd_i.pre_zero ? t2i64_pkg::ST_SOME : stat_cur;

  // candidate bases
  assign base_dec = (number_base_q == '0) ? t2i64_pkg::BASE_DEC : number_base_q;
  assign base_oct = (number_base_q == '0) ? t2i64_pkg::BASE_OCT : number_base_q;
  assign base_act = (base_cur == '0) ? t2i64_pkg::BASE_DEC : base_cur;

  assign status_o.digit_ok_first = cd.valid && (cd.value < base_dec);
  assign status_o.digit_ok_octal = cd.valid && (cd.value < base_oct);
  assign status_o.digit_ok_keep  = cd.valid && (cd.value < base_act);
  assign status_o.out_full       = out_valid_q;

  always_comb begin
    case (cmd_i.base_sel)
      t2i64_pkg::BASE_FIRST: base_eff = base_dec;
      t2i64_pkg::BASE_OCTAL: base_eff = base_oct;
      t2i64_pkg::BASE_HEX:   base_eff = t2i64_pkg::BASE_HX;
      default:               base_eff = base_act;
    endcase
  end

  // magnitude limit, also the saturated value
  assign limit = !signed_mode_q ? '1 :
                 (neg_cur ? t2i64_pkg::LIMIT_SIGNED_MIN : t2i64_pkg::LIMIT_SIGNED_MAX);

  // multiply-add and overflow compare against the limit
  assign prod = {{BaseW{1'b0}}, acc_cur} * {{ValueW{1'b0}}, base_eff};
  assign sum  = {1'b0, prod} + {{(ValueW+1){1'b0}}, cd.value};
  assign over = sum > {{(BaseW+1){1'b0}}, limit};

  // next string state
  always_comb begin
    acc_d  = acc_cur;
    neg_d  = neg_cur || cmd_i.set_neg;
    stat_d = stat_pre;
    base_d = (cmd_i.base_sel == t2i64_pkg::BASE_KEEP) ? base_cur : base_eff;
    pos_d  = (pos_cur == '1) ? pos_cur : pos_cur + 1'b1;
    if (cmd_i.digit) begin
      if ((stat_pre == t2i64_pkg::ST_OVER) || over) begin
        stat_d = t2i64_pkg::ST_OVER;
      end else begin
        stat_d = t2i64_pkg::ST_SOME;
        acc_d  = sum[ValueW-1:0];
      end
    end
  end

  // result fields
  assign pos_ext   = ExtW'(pos_cur);
  assign res_conv  = stat_pre != t2i64_pkg::ST_NONE;
  assign res_value = (stat_pre == t2i64_pkg::ST_OVER) ? limit :
                     (neg_cur ? ('0 - acc_cur) : acc_cur);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        t2i64_pkg::REG_NUMBER_BASE: number_base_q <= cfg_wdata_i[BaseW-1:0];
        t2i64_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // string state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stat_q <= t2i64_pkg::ST_NONE;
      base_q <= '0;
      pos_q  <= '0;
    end else if (cmd_i.step) begin
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      stat_q <= stat_d;
      base_q <= base_d;
      pos_q  <= pos_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      value_q <= res_value;
      range_q <= stat_pre == t2i64_pkg::ST_OVER;
      conv_q  <= res_conv;
      end_q   <= res_conv ? pos_ext[EndW-1:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_bits_o  = value_q;
  assign range_error_o = range_q;
  assign converted_o   = conv_q;
  assign end_offset_o  = end_q;

  `T2I_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni, cmd_i.finish, out_valid_q)
  `T2I_ASSERT_IMPLIES(a_range_conv, clk_i, rst_ni, out_valid_q && range_q, conv_q)
  `T2I_ASSERT_IMPLIES(a_none_zero, clk_i, rst_ni, out_valid_q && !conv_q, value_q == '0 && end_q == '0)

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import t2i64_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 8;
  localparam int PHASE_CHARS  = 40;
  localparam int NOT_DIGIT    = 64;
  localparam logic [31:0] POS_MAX = (32'd1 << OffsetBitsDefault) - 32'd1;

  typedef enum int {TX_STREAM, TX_SHORT_GAPS, TX_BURSTY} tx_mode_e;
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [ValueW-1:0]     value;
    logic                  range_err;
    logic                  conv;
    logic [EndOffsetW-1:0] offset;
  } conv_result_t;

  // streaming strtoull / strtoll predictor plus the queue of results it expects
  class parse_scoreboard;
    logic [BaseW-1:0] number_base;
    bit               signed_mode;
    phase_e           phase;
    logic [63:0]      acc;
    bit               neg;
    digit_status_e    status;
    logic [BaseW-1:0] run_base;
    logic [31:0]      pos;
    conv_result_t     expected_values[$];
    int               errors;
    int               checked;
    int               saturated;

    function new();
      number_base = '0;
      signed_mode = 1'b0;
      phase = PH_IDLE;
      clear_string();
    endfunction

    function void clear_string();
      acc = '0;
      neg = 1'b0;
      status = ST_NONE;
      run_base = '0;
      pos = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == REG_NUMBER_BASE) begin
        number_base = data;
      end else if (idx == REG_SIGNED_MODE) begin
        signed_mode = data[0];
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function int digit_value(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) - int'(CHAR_UPPER_OFS);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c) - int'(CHAR_LOWER_OFS);
      return NOT_DIGIT;
    endfunction

    // magnitude that saturation clamps to
    function logic [63:0] sat_limit();
      if (signed_mode) return neg ? LIMIT_SIGNED_MIN : LIMIT_SIGNED_MAX;
      return '1;
    endfunction

    // multiply-add with the cutoff overflow rule
    function void take_digit(int d);
      logic [63:0] b;
      logic [63:0] lim;
      logic [63:0] cut;
      logic [63:0] rem;
      b = (run_base != 0) ? 64'(run_base) : 64'(BASE_DEC);
      lim = sat_limit();
      cut = lim / b;
      rem = lim % b;
      if (status == ST_OVER || acc > cut || (acc == cut && 64'(d) > rem)) begin
        status = ST_OVER;
      end else begin
        status = ST_SOME;
        acc = acc * b + 64'(d);
      end
    endfunction

    function void close_string();
      conv_result_t r;
      if (status == ST_OVER) begin
        r.value = sat_limit();
        saturated++;
      end else begin
        r.value = neg ? 64'd0 - acc : acc;
      end
      r.range_err = (status == ST_OVER);
      r.conv = (status != ST_NONE);
      r.offset = r.conv ? pos[EndOffsetW-1:0] : '0;
      expected_values.push_back(r);
      phase = PH_DONE;
    endfunction

    function void digit_step(logic [7:0] c);
      int d;
      int b;
      d = digit_value(c);
      b = (run_base != 0) ? int'(run_base) : int'(BASE_DEC);
      if (d >= b) close_string();
      else take_digit(d);
    endfunction

    // first character after whitespace and sign
    function void first_step(logic [7:0] c);
      if ((number_base == 0 || number_base == BASE_HX) && c == CHAR_ZERO) begin
        phase = PH_ZERO;
      end else begin
        run_base = (number_base != 0) ? number_base : BASE_DEC;
        phase = PH_DIGITS;
        digit_step(c);
      end
    endfunction

    function void note_request(logic [7:0] c, logic start);
      if (start) begin
        clear_string();
        phase = PH_LEAD;
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;
      case (phase)
        PH_LEAD: begin
          if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            // leading whitespace is skipped
          end else if (c == CHAR_MINUS) begin
            neg = 1'b1;
            phase = PH_SIGNED;
          end else if (c == CHAR_PLUS) begin
            phase = PH_SIGNED;
          end else begin
            first_step(c);
          end
        end
        PH_SIGNED: begin
          first_step(c);
        end
        PH_ZERO: begin
          if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
            run_base = BASE_HX;
            phase = PH_PREFIX;
          end else begin
            // the leading zero counts as a digit
            run_base = (number_base != 0) ? number_base : BASE_OCT;
            phase = PH_DIGITS;
            take_digit(0);
            digit_step(c);
          end
        end
        PH_PREFIX: begin
          phase = PH_DIGITS;
          digit_step(c);
        end
        default: begin
          digit_step(c);
        end
      endcase
      if (pos < POS_MAX) pos++;
    endfunction

    task check_result(conv_result_t got);
      conv_result_t want;
      if (expected_values.size() == 0) begin
        report($sformatf("unexpected result value=%h", got.value));
        return;
      end
      want = expected_values.pop_front();
      checked++;
      if (got.value !== want.value)
        report($sformatf("value_bits got %h want %h", got.value, want.value));
      if (got.range_err !== want.range_err)
        report($sformatf("range_error got %b want %b", got.range_err, want.range_err));
      if (got.conv !== want.conv)
        report($sformatf("converted got %b want %b", got.conv, want.conv));
      if (got.offset !== want.offset)
        report($sformatf("end_offset got %0d want %0d", got.offset, want.offset));
    endtask
  endclass

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  t2i64_in_if  in_ch ();
  t2i64_out_if out_ch ();

  text_to_int64_parser_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  parse_scoreboard sb = new();

  logic [7:0] text_q[$];
  tx_mode_e   tx_mode;
  int         burst_left;
  int         chars_sent;
  int         settings_run;
  int         idle_cycles;
  rx_mode_e   rx_mode;
  int         rx_left;
  int         rx_tick;
  conv_result_t got_result;

  // hand-picked strings: {string_start, character}
  logic [8:0] directed[$] = '{
    {1'b0, "Z"},                                       // before any string: ignored
    {1'b1, CHAR_SPACE}, {1'b0, CHAR_MINUS}, {1'b0, "0"}, {1'b0, "x"},
    {1'b0, "1"}, {1'b0, "f"}, {1'b0, "g"},             // negative hex
    {1'b1, "0"}, {1'b0, "X"}, {1'b0, "z"},             // bare hex prefix
    {1'b1, "0"}, {1'b0, "1"}, {1'b0, "7"}, {1'b0, "9"}, // octal from leading zero
    {1'b0, "A"},                                       // after the result: ignored
    {1'b1, CHAR_PLUS}, {1'b0, CHAR_TAB}, {1'b0, "5"},  // whitespace after sign
    {1'b1, "1"}, {1'b0, "2"}, {1'b1, 8'hFF},           // restart drops the old string
    {1'b1, CHAR_CR}, {1'b0, "9"}, {1'b0, 8'h00}
  };

  always #2 clk = ~clk;

  // receiver stall patterns, redrawn at random
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS:   out_ch.ready <= 1'b1;
      RX_HALF:     out_ch.ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:     out_ch.ready <= ((rx_tick % 7) < 3);
    endcase
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.char_code, in_ch.string_start);
      if (out_ch.valid && out_ch.ready) begin
        got_result.value = out_ch.value_bits;
        got_result.range_err = out_ch.range_error;
        got_result.conv = out_ch.converted;
        got_result.offset = out_ch.end_offset;
        sb.check_result(got_result);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // one character request, with burst gaps in front as the sender mode asks
  task automatic send_char(logic [7:0] c, logic start);
    int gap;
    if (burst_left <= 0) begin
      case (tx_mode)
        TX_STREAM:     gap = 0;
        TX_SHORT_GAPS: gap = $urandom_range(0, 2);
        default:       gap = $urandom_range(1, 8);
      endcase
      burst_left = (tx_mode == TX_BURSTY) ? $urandom_range(1, 6) : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.string_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(bit allow_restart);
    foreach (text_q[i])
      send_char(text_q[i], i == 0 || (allow_restart && $urandom_range(0, 99) == 0));
  endtask

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d - 10);
  endfunction

  // one string: mostly well-formed numbers, some near the saturation point, some noise
  task automatic build_text();
    int kind;
    int eb;
    int sign_sel;
    int len_sel;
    int n_digits;
    int delta;
    bit at_limit;
    logic [64:0] mag;
    logic [7:0] digs[$];
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    at_limit = (kind >= 60) && (sb.number_base <= 36);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
      if ($urandom_range(0, 1)) text_q.push_back(CHAR_SPACE);
      else text_q.push_back(CHAR_TAB + 8'($urandom_range(0, 4)));
    end
    sign_sel = $urandom_range(0, 2);
    if (sign_sel == 1) text_q.push_back(CHAR_MINUS);
    if (sign_sel == 2) text_q.push_back(CHAR_PLUS);
    // prefix and the base the digits are drawn from
    if (sb.number_base == 0) begin
      case ($urandom_range(0, 2))
        0: eb = 10;
        1: begin
          eb = 16;
          text_q.push_back(CHAR_ZERO);
          text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
        end
        default: begin
          eb = 8;
          text_q.push_back(CHAR_ZERO);
        end
      endcase
    end else if (sb.number_base == BASE_HX && $urandom_range(0, 1)) begin
      eb = 16;
      text_q.push_back(CHAR_ZERO);
      text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
    end else begin
      eb = (sb.number_base > 36) ? 36 : int'(sb.number_base);
    end
    if (at_limit && eb > 1) begin
      if (!sb.signed_mode) mag = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      else if (sign_sel == 1) mag = {1'b0, LIMIT_SIGNED_MIN};
      else mag = {1'b0, LIMIT_SIGNED_MAX};
      delta = $urandom_range(0, 4) - 2;
      if (delta < 0) mag = mag - 65'(-delta);
      else mag = mag + 65'(delta);
      while (mag != 0) begin
        digs.push_front(digit_char(int'(mag % 65'(eb))));
        mag = mag / 65'(eb);
      end
    end else begin
      len_sel = $urandom_range(0, 9);
      if (len_sel == 0) n_digits = 0;
      else if (len_sel <= 5) n_digits = $urandom_range(1, 4);
      else if (len_sel <= 8) n_digits = $urandom_range(5, 24);
      else n_digits = $urandom_range(25, 70);
      repeat (n_digits) digs.push_back(digit_char($urandom_range(0, eb - 1)));
    end
    foreach (digs[i]) text_q.push_back(digs[i]);
    // terminator
    case ($urandom_range(0, 3))
      0: text_q.push_back(8'($urandom_range(0, 255)));
      1: text_q.push_back(CHAR_SPACE);
      2: text_q.push_back(eb < 36 ? digit_char(eb) : 8'h3B);
      default: text_q.push_back(8'h3B);
    endcase
    // trailing random characters, ignored once a result has been produced
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // wait until every expected result is in and the block has settled
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_values.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int base, bit is_signed);
    wait_drain();
    write_reg(REG_NUMBER_BASE, CfgDataW'(base));
    // upper bits of the signed-mode write carry random junk
    write_reg(REG_SIGNED_MODE, {5'($urandom_range(0, 31)), is_signed});
    tx_mode = tx_mode_e'($urandom_range(0, 2));
    settings_run++;
  endtask

  task automatic run_random(int base, bit is_signed);
    int start_count;
    configure(base, is_signed);
    start_count = chars_sent;
    while (chars_sent - start_count < PHASE_CHARS) begin
      build_text();
      send_text(1'b1);
    end
  endtask

  int fixed_bases[10]  = '{0, 10, 16, 0, 8, 2, 36, 1, 63, 37};
  bit fixed_signed[10] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0};

  initial begin
    clk = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.string_start = 1'b0;
    out_ch.ready = 1'b0;
    burst_left = 0;
    chars_sent = 0;
    settings_run = 1;
    idle_cycles = 0;
    rx_left = 0;
    rx_tick = 0;
    tx_mode = tx_mode_e'($urandom_range(0, 2));
    repeat (2) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed strings at the reset settings
    foreach (directed[i]) send_char(directed[i][7:0], directed[i][8]);

    // random strings over fixed and random register settings
    foreach (fixed_bases[i]) run_random(fixed_bases[i], fixed_signed[i]);
    repeat (3) run_random($urandom_range(0, 63), 1'($urandom_range(0, 1)));

    wait_drain();
    $display("covered %0d characters over %0d register settings", chars_sent, settings_run);
    $display("%0d results checked, %0d of them saturated", sb.checked, sb.saturated);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
